// ===== sv/iss_pkg.sv =====
`default_nettype none

package iss_pkg;

   // Default number of members the store can hold.
   localparam int DEFAULT_CAPACITY = 16;

   // Request kinds; the unused code is served as a lookup.
   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_LOOKUP = 2'd2
   } action_type;

   // Token that walks the row of cells, one cell per cycle.
   typedef struct packed {
      logic               valid;
      logic [1:0]         action;
      logic signed [31:0] value;
      logic               found;
      logic               any;
      logic signed [31:0] lo;
      logic signed [31:0] hi;
   } token_type;

endpackage

`default_nettype wire

// ===== sv/integer_set_store_core.sv =====
`default_nettype none
// Channel   Ports                                   Beat taken when
// -------   -------------------------------------   --------------------------
// request   start, busy, req_action, req_value      start high and busy low
// result    rsp_valid, rsp_was_present, ...         rsp_valid high (one cycle)
//
// A request beat walks the row of CAPACITY cells one cell per cycle, and a new
// request is accepted only once the token has left the last cell, so the row
// length sets how soon the next request can be taken.
// The result shows on the rsp_ ports for one cycle, in the cycle busy drops.
// Reset clears the member count and the control flags; entries are not cleared.
// The receiver cannot stall, so no result is ever held back.

module integer_set_store_core
   import iss_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY,
   localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_action,
   input  wire logic signed [31:0] req_value,
   output logic                    rsp_valid,
   output logic                    rsp_was_present,
   output logic                    rsp_refused_full,
   output logic [4:0]              rsp_member_count,
   output logic                    rsp_is_empty,
   output logic signed [31:0]      rsp_smallest,
   output logic signed [31:0]      rsp_largest
);

   localparam logic [CNT_W-1:0] CAP_CNT = CAPACITY[CNT_W-1:0];
   localparam logic [CNT_W-1:0] ONE_CNT = {{(CNT_W-1){1'b0}}, 1'b1};

   logic                    busy_ff;
   logic                    busy_in;
   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;
   token_type               launch_ff;
   token_type               launch_in;
   logic                    accept;
   logic                    refused;
   logic [CNT_W+4:0]        count_ext;
   token_type               tok      [CAPACITY+1];
   logic signed [31:0]      stored   [CAPACITY];
   logic                    rsp_valid_ff;
   logic                    rsp_was_present_ff;
   logic                    rsp_refused_full_ff;
   logic [4:0]              rsp_member_count_ff;
   logic                    rsp_is_empty_ff;
   logic signed [31:0]      rsp_smallest_ff;
   logic signed [31:0]      rsp_largest_ff;
   token_type               tail;

   assign accept = start && !busy_ff;
   assign tail   = tok[CAPACITY];

   // Build the token that enters the first cell.
   always_comb begin
      launch_in        = '0;
      launch_in.valid  = accept;
      launch_in.action = req_action;
      launch_in.value  = req_value;
   end

   // Busy from acceptance until the token leaves the last cell.
   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (tail.valid) begin
         busy_in = 1'b0;
      end
   end

   // Member count after the request, from what the token found.
   always_comb begin
      refused  = 1'b0;
      count_in = count_ff;
      if (tail.valid) begin
         if ((tail.action == ACT_INSERT) && !tail.found) begin
            if (count_ff == CAP_CNT) begin
               refused = 1'b1;
            end else begin
               count_in = count_ff + ONE_CNT;
            end
         end else if ((tail.action == ACT_REMOVE) && tail.found) begin
            count_in = count_ff - ONE_CNT;
         end
      end
   end

   assign count_ext = {5'b0, count_in};

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff         <= 1'b0;
         count_ff        <= '0;
         launch_ff.valid <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= tail.valid;
      end
   end

   // Result registers.
   always_ff @(posedge clock) begin
      if (tail.valid) begin
         rsp_was_present_ff  <= tail.found;
         rsp_refused_full_ff <= refused;
         rsp_member_count_ff <= count_ext[4:0];
         rsp_is_empty_ff     <= count_in == '0;
         rsp_smallest_ff     <= tail.any ? tail.lo : 32'sd0;
         rsp_largest_ff      <= tail.any ? tail.hi : 32'sd0;
      end
   end

   assign tok[0] = launch_ff;

   // Row of cells; each reads its upper neighbor when compacting, the last cell reads the first.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [31:0] upper;
      if (i == CAPACITY - 1) begin : g_last
         assign upper = stored[0];
      end else begin : g_mid
         assign upper = stored[i+1];
      end
      iss_cell #(
         .CAPACITY (CAPACITY),
         .INDEX    (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .count      (count_ff),
         .tok_in     (tok[i]),
         .tok_out    (tok[i+1]),
         .next_val   (upper),
         .stored_val (stored[i])
      );
   end

   assign busy             = busy_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_was_present  = rsp_was_present_ff;
   assign rsp_refused_full = rsp_refused_full_ff;
   assign rsp_member_count = rsp_member_count_ff;
   assign rsp_is_empty     = rsp_is_empty_ff;
   assign rsp_smallest     = rsp_smallest_ff;
   assign rsp_largest      = rsp_largest_ff;

endmodule

`default_nettype wire

// ===== sv/iss_cell.sv =====
`default_nettype none

module iss_cell
   import iss_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY,
   parameter int INDEX    = 0,
   localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [CNT_W-1:0]   count,
   input  wire token_type          tok_in,
   output token_type               tok_out,
   input  wire logic signed [31:0] next_val,
   output logic signed [31:0]      stored_val
);

   localparam int                 NEXT_INDEX = INDEX + 1;
   localparam logic [CNT_W-1:0]   IDX        = INDEX[CNT_W-1:0];
   localparam logic [CNT_W-1:0]   IDX_P1     = NEXT_INDEX[CNT_W-1:0];

   logic signed [31:0] stored_ff;
   logic signed [31:0] stored_in;
   logic               write_en;
   logic               keep;
   logic               occupied;
   logic               hit;
   logic               found_now;
   token_type          tok_ff;
   token_type          tok_in_next;

   // Decide what this entry holds after the request and whether it stays a member.
   always_comb begin
      occupied  = IDX < count;
      hit       = occupied && (stored_ff == tok_in.value);
      found_now = tok_in.found | hit;
      write_en  = 1'b0;
      stored_in = stored_ff;
      keep      = occupied;
      if ((tok_in.action == ACT_REMOVE) && found_now) begin
         // Entries from the match onward take their upper neighbor's value.
         write_en  = 1'b1;
         stored_in = next_val;
         keep      = IDX_P1 < count;
      end else if ((tok_in.action == ACT_INSERT) && !tok_in.found && (IDX == count)) begin
         // First free entry takes a new value once the whole set was searched.
         write_en  = 1'b1;
         stored_in = tok_in.value;
         keep      = 1'b1;
      end
   end

   // Fold the surviving entry into the running minimum and maximum.
   always_comb begin
      tok_in_next       = tok_in;
      tok_in_next.found = found_now;
      if (keep) begin
         if (!tok_in.any) begin
            tok_in_next.any = 1'b1;
            tok_in_next.lo  = stored_in;
            tok_in_next.hi  = stored_in;
         end else begin
            if (stored_in < tok_in.lo) begin
               tok_in_next.lo = stored_in;
            end
            if (stored_in > tok_in.hi) begin
               tok_in_next.hi = stored_in;
            end
         end
      end
   end

   // Entry storage is written only as the token passes.
   always_ff @(posedge clock) begin
      if (tok_in.valid && write_en) begin
         stored_ff <= stored_in;
      end
   end

   // Hand the token on to the next cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in_next;
      end
   end

   assign tok_out    = tok_ff;
   assign stored_val = stored_ff;

endmodule

`default_nettype wire

// ===== sv/iss_checker.sv =====
`default_nettype none

module iss_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               start,
   input wire logic               busy,
   input wire logic               rsp_valid,
   input wire logic               rsp_was_present,
   input wire logic               rsp_refused_full,
   input wire logic               rsp_is_empty,
   input wire logic signed [31:0] rsp_smallest,
   input wire logic signed [31:0] rsp_largest
);

   // An accepted request beat keeps the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not raise busy");

   // Each request gives a single one-cycle result beat.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe lasted more than one cycle");

   // A refused insert can only concern a value that was absent.
   a_refused_absent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_refused_full |-> !rsp_was_present)
      else $error("refused insert reported a present value");

   // An empty set reports zero bounds.
   a_empty_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> (rsp_smallest == 32'sd0) && (rsp_largest == 32'sd0))
      else $error("empty set reported nonzero bounds");

   // A non-empty set has ordered bounds.
   a_ordered_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_empty |-> rsp_smallest <= rsp_largest)
      else $error("smallest member above largest member");

endmodule

bind integer_set_store_core iss_checker u_iss_checker (.*);

`default_nettype wire
